>>> design/serial_frame_deframer_core_macros.svh
// ----------------------------------------------------------------------------
// Serial frame deframer assertion macros
// Checks used by the deframer top level. Each macro compiles away when SYNTH
// is defined.
// ----------------------------------------------------------------------------
`ifndef SERIAL_FRAME_DEFRAMER_CORE_MACROS_SVH
`define SERIAL_FRAME_DEFRAMER_CORE_MACROS_SVH

`ifndef SYNTH
// The consequent must hold in the same cycle as the antecedent.
`define SFD_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("deframer check failed");
// The consequent must hold in the cycle after the antecedent.
`define SFD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("deframer check failed");
`else
`define SFD_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define SFD_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

>>> design/sfd_pkg.sv
// ----------------------------------------------------------------------------
// Serial frame deframer package
// Word types, configuration type, parser phases, field kinds and register map.
// ----------------------------------------------------------------------------
package sfd_pkg;

    // Field kinds reported with every echoed byte.
    localparam logic [2:0] KIND_DROP    = 3'd0;
    localparam logic [2:0] KIND_FLAG    = 3'd1;
    localparam logic [2:0] KIND_SOURCE  = 3'd2;
    localparam logic [2:0] KIND_REMOTE  = 3'd3;
    localparam logic [2:0] KIND_LENGTH  = 3'd4;
    localparam logic [2:0] KIND_PAYLOAD = 3'd5;
    localparam logic [2:0] KIND_CRC     = 3'd6;

    // Register indexes (byte address is four times the index).
    localparam logic [1:0] REG_BEGIN_FLAG  = 2'd0;
    localparam logic [1:0] REG_ESCAPE_FLAG = 2'd1;
    localparam logic [1:0] REG_GAP_TIMEOUT = 2'd2;

    // Register reset values.
    localparam logic [7:0] BEGIN_FLAG_RST  = 8'h7E;
    localparam logic [7:0] ESCAPE_FLAG_RST = 8'h7D;
    localparam logic [7:0] GAP_TIMEOUT_RST = 8'd5;

    // Number of CRC bytes after which a frame is complete.
    localparam logic [1:0] CRC_BYTES = 2'd2;

    // Position of the parser within a frame.
    typedef enum logic [2:0] {
        PH_FLAG    = 3'd0,
        PH_SOURCE  = 3'd1,
        PH_REMOTE  = 3'd2,
        PH_LENGTH  = 3'd3,
        PH_PAYLOAD = 3'd4,
        PH_CRC     = 3'd5
    } t_phase;

    typedef struct packed {
        logic [7:0] data_byte;
        logic [7:0] idle_ms;
    } t_in_word;

    typedef struct packed {
        logic [7:0]  out_byte;
        logic [2:0]  field_kind;
        logic        frame_done;
        logic        frame_abort;
        logic [7:0]  frame_source;
        logic [7:0]  frame_remote;
        logic [15:0] frame_length;
    } t_out_word;

    typedef struct packed {
        logic [7:0] begin_flag;
        logic [7:0] escape_flag;
        logic [7:0] gap_timeout_ms;
    } t_cfg;

endpackage

>>> design/sfd_parser.sv
// ----------------------------------------------------------------------------
// Serial frame deframer parser
// Holds the frame state and classifies one accepted byte per cycle.
// ----------------------------------------------------------------------------
module sfd_parser
    import sfd_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_accept,
    input  t_in_word  i_word,
    input  t_cfg      i_cfg,
    output t_out_word o_result
);

    t_phase      r_phase,        n_phase;
    logic [7:0]  r_source,       n_source;
    logic [7:0]  r_remote,       n_remote;
    logic [15:0] r_length,       n_length;
    logic        r_len_low,      n_len_low;
    logic [15:0] r_payload_seen, n_payload_seen;
    logic [1:0]  r_crc_seen,     n_crc_seen;

    t_phase      cur_phase;
    logic        cur_len_low;
    logic        timeout;
    logic [15:0] seen_inc;
    logic [1:0]  crc_inc;
    logic [2:0]  kind;
    logic        done;
    logic        abort;

    // Frame state; all of it is control and clears on reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase        <= PH_FLAG;
            r_source       <= '0;
            r_remote       <= '0;
            r_length       <= '0;
            r_len_low      <= 1'b0;
            r_payload_seen <= '0;
            r_crc_seen     <= '0;
        end else if (i_accept) begin
            r_phase        <= n_phase;
            r_source       <= n_source;
            r_remote       <= n_remote;
            r_length       <= n_length;
            r_len_low      <= n_len_low;
            r_payload_seen <= n_payload_seen;
            r_crc_seen     <= n_crc_seen;
        end
    end

    // Timeout check first, then parse the byte at the resulting phase.
    always_comb begin
        timeout        = i_word.idle_ms > i_cfg.gap_timeout_ms;
        abort          = timeout && (r_phase != PH_FLAG);
        cur_phase      = timeout ? PH_FLAG : r_phase;
        cur_len_low    = timeout ? 1'b0 : r_len_low;
        seen_inc       = r_payload_seen + 16'd1;
        crc_inc        = r_crc_seen + 2'd1;

        n_phase        = cur_phase;
        n_source       = r_source;
        n_remote       = r_remote;
        n_length       = r_length;
        n_len_low      = cur_len_low;
        n_payload_seen = r_payload_seen;
        n_crc_seen     = r_crc_seen;
        kind           = KIND_DROP;
        done           = 1'b0;

        unique case (cur_phase)
            PH_FLAG: begin
                if (i_word.data_byte == i_cfg.begin_flag ||
                    i_word.data_byte == i_cfg.escape_flag) begin
                    kind    = KIND_FLAG;
                    n_phase = PH_SOURCE;
                end
            end
            PH_SOURCE: begin
                kind     = KIND_SOURCE;
                n_source = i_word.data_byte;
                n_phase  = PH_REMOTE;
            end
            PH_REMOTE: begin
                kind     = KIND_REMOTE;
                n_remote = i_word.data_byte;
                n_phase  = PH_LENGTH;
            end
            PH_LENGTH: begin
                kind = KIND_LENGTH;
                if (!cur_len_low) begin
                    n_length  = {8'd0, i_word.data_byte};
                    n_len_low = 1'b1;
                end else begin
                    n_length       = {i_word.data_byte, r_length[7:0]};
                    n_len_low      = 1'b0;
                    n_payload_seen = '0;
                    n_phase        = PH_PAYLOAD;
                end
            end
            PH_PAYLOAD: begin
                // A zero length still ends after the first payload byte.
                kind           = KIND_PAYLOAD;
                n_payload_seen = seen_inc;
                if (seen_inc >= r_length) begin
                    n_crc_seen = '0;
                    n_phase    = PH_CRC;
                end
            end
            PH_CRC: begin
                kind       = KIND_CRC;
                n_crc_seen = crc_inc;
                if (crc_inc >= CRC_BYTES) begin
                    done    = 1'b1;
                    n_phase = PH_FLAG;
                end
            end
            default: begin
                // Unused phase codes fall back to waiting for a flag.
                n_phase   = PH_FLAG;
                n_len_low = 1'b0;
            end
        endcase

        o_result.out_byte     = i_word.data_byte;
        o_result.field_kind   = kind;
        o_result.frame_done   = done;
        o_result.frame_abort  = abort;
        o_result.frame_source = n_source;
        o_result.frame_remote = n_remote;
        o_result.frame_length = n_length;
    end

endmodule

>>> design/serial_frame_deframer_core.sv
// ----------------------------------------------------------------------------
// Serial frame deframer core
// Each accepted byte is classified in the cycle it is taken and its result
// word is placed in a two-entry output buffer. A byte can be accepted every
// cycle, one word per cycle sustained; each result word is registered in the
// buffer. Input stalls only when both output entries are full.
// ----------------------------------------------------------------------------
module serial_frame_deframer_core
    import sfd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Byte input channel.
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  t_in_word    i_in_data,
    // Result output channel.
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output t_out_word   o_out_data,
    // Configuration port.
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

`include "serial_frame_deframer_core_macros.svh"

    t_cfg      r_cfg;
    t_out_word result;
    t_out_word r_out;
    t_out_word r_skid;
    logic      r_out_valid;
    logic      r_skid_valid;
    logic      in_accept;
    logic      out_pop;
    logic      cfg_write;
    logic [1:0] reg_idx;
    logic      chk_done;
    logic      chk_abort;
    logic      chk_kind_crc;
    logic      chk_kind_start;

    assign pready    = 1'b1;
    assign reg_idx   = paddr[3:2];
    assign cfg_write = psel && penable && pwrite;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.begin_flag     <= BEGIN_FLAG_RST;
            r_cfg.escape_flag    <= ESCAPE_FLAG_RST;
            r_cfg.gap_timeout_ms <= GAP_TIMEOUT_RST;
        end else if (cfg_write) begin
            unique case (reg_idx)
                REG_BEGIN_FLAG:  r_cfg.begin_flag     <= pwdata[7:0];
                REG_ESCAPE_FLAG: r_cfg.escape_flag    <= pwdata[7:0];
                REG_GAP_TIMEOUT: r_cfg.gap_timeout_ms <= pwdata[7:0];
                default: begin
                end
            endcase
        end
    end

    // Register read-back.
    always_comb begin
        unique case (reg_idx)
            REG_BEGIN_FLAG:  prdata = {24'd0, r_cfg.begin_flag};
            REG_ESCAPE_FLAG: prdata = {24'd0, r_cfg.escape_flag};
            REG_GAP_TIMEOUT: prdata = {24'd0, r_cfg.gap_timeout_ms};
            default:         prdata = '0;
        endcase
    end

    // Byte classification and frame state.
    sfd_parser u_parser (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (in_accept),
        .i_word   (i_in_data),
        .i_cfg    (r_cfg),
        .o_result (result)
    );

    assign o_in_ready  = !r_skid_valid;
    assign in_accept   = i_in_valid && o_in_ready;
    assign out_pop     = r_out_valid && i_out_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // Output buffer: main word plus one skid word.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (in_accept) begin
            if (!r_out_valid || out_pop) begin
                r_out_valid <= 1'b1;
            end else begin
                r_skid_valid <= 1'b1;
            end
        end else if (out_pop) begin
            if (r_skid_valid) begin
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Output buffer payload.
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            if (!r_out_valid || out_pop) begin
                r_out <= result;
            end else begin
                r_skid <= result;
            end
        end else if (out_pop && r_skid_valid) begin
            r_out <= r_skid;
        end
    end

    // Terms used by the checks below.
    assign chk_done       = r_out_valid && r_out.frame_done;
    assign chk_abort      = r_out_valid && r_out.frame_abort;
    assign chk_kind_crc   = r_out.field_kind == KIND_CRC;
    assign chk_kind_start = r_out.field_kind == KIND_DROP || r_out.field_kind == KIND_FLAG;

    // Checks on buffer occupancy and result consistency.
    `SFD_ASSERT_SAME(a_skid_needs_main, i_clk, i_rst_n, r_skid_valid, r_out_valid)
    `SFD_ASSERT_SAME(a_done_on_crc, i_clk, i_rst_n, chk_done, chk_kind_crc)
    `SFD_ASSERT_SAME(a_abort_kind, i_clk, i_rst_n, chk_abort, chk_kind_start)
    `SFD_ASSERT_NEXT(a_full_stalls, i_clk, i_rst_n, r_skid_valid && !i_out_ready, r_skid_valid)

endmodule
